FILE: rtl/brec_pkg.sv
// ----------------------------------------------------------------------------
// brec_pkg: shared types and constants for the BCD RTC epoch clock
// Beat structs, command codes, state and ALU op enums, calendar helpers.
// ----------------------------------------------------------------------------
package brec_pkg;

  localparam int unsigned TPS_W     = 16;
  localparam int unsigned REM_W     = 6;

  localparam logic [31:0] DAYS_TO_2000  = 32'd10957;
  localparam logic [31:0] DAYS_PER_YEAR = 32'd365;
  localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
  localparam logic [5:0]  MIN_PER_HOUR  = 6'd60;
  localparam logic [5:0]  HOUR_PER_DAY  = 6'd24;

  // floor(x / 60) = (x * RECIP_60) >> 37, floor(x / 24) = (x * RECIP_24) >> 36
  localparam logic [31:0] RECIP_60 = 32'h8888_8889;
  localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] PASS_HOUR = 2'd0;
  localparam logic [1:0] PASS_MIN  = 2'd1;
  localparam logic [1:0] PASS_SEC  = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] bcd_second;
    logic [7:0] bcd_minute;
    logic [7:0] bcd_hour;
    logic [7:0] bcd_day;
    logic [7:0] bcd_month;
    logic [7:0] bcd_year;
  } brec_in_t;

  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
  } brec_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DIV,
    S_REM,
    S_DONE
  } brec_state_t;

  typedef enum logic [1:0] {
    ALU_MAC,
    ALU_DIV,
    ALU_REM
  } brec_op_t;

  typedef struct packed {
    brec_op_t   op;
    logic [5:0] k;
  } brec_alu_ctrl_t;

  function automatic logic [7:0] bcd_byte_value(input logic [7:0] b);
    return 8'(b[7:4] * 8'd10) + 8'(b[3:0]);
  endfunction

  // days before the first of the month, zero for a month outside 1..12
  function automatic logic [8:0] month_start(input logic [7:0] m);
    logic [8:0] d;
    case (m)
      8'd2:    d = 9'd31;
      8'd3:    d = 9'd59;
      8'd4:    d = 9'd90;
      8'd5:    d = 9'd120;
      8'd6:    d = 9'd151;
      8'd7:    d = 9'd181;
      8'd8:    d = 9'd212;
      8'd9:    d = 9'd243;
      8'd10:   d = 9'd273;
      8'd11:   d = 9'd304;
      8'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/brec_alu.sv
// ----------------------------------------------------------------------------
// brec_alu: shared arithmetic unit
// One 32x32 multiplier. MAC: y = a * k + addend (mod 2^32). DIV: quotient
// of a by 24 (k = 24) or 60 (else) via reciprocal. REM: remainder of that DIV.
// ----------------------------------------------------------------------------
module brec_alu
  import brec_pkg::*;
(
  input  brec_alu_ctrl_t   ctrl_i,
  input  logic [31:0]      a_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [7:0]       addend_i,
  output logic [31:0]      y_o,
  output logic [REM_W-1:0] rem_o
);

  logic        by_day;
  logic [31:0] mul_b;
  logic [63:0] prod;

  assign by_day = (ctrl_i.k == HOUR_PER_DAY);
  assign mul_b  = (ctrl_i.op == ALU_MAC) ? {26'd0, ctrl_i.k}
                                         : (by_day ? RECIP_24 : RECIP_60);
  assign prod   = {32'd0, a_i} * {32'd0, mul_b};

  always_comb begin
    unique case (ctrl_i.op)
      ALU_MAC: begin
        y_o   = prod[31:0] + {24'd0, addend_i};
        rem_o = rem_i;
      end
      ALU_DIV: begin
        // low dividend bits ride along for the remainder step
        y_o   = by_day ? {4'd0, prod[63:36]} : {5'd0, prod[63:37]};
        rem_o = a_i[REM_W-1:0];
      end
      ALU_REM: begin
        // remainder is below 64, so the low bits of a - q*k are enough
        y_o   = a_i;
        rem_o = REM_W'(rem_i - REM_W'(a_i[REM_W-1:0] * ctrl_i.k));
      end
      default: begin
        y_o   = a_i;
        rem_o = rem_i;
      end
    endcase
  end

endmodule

FILE: rtl/bcd_rtc_epoch_clock_unit.sv
// ----------------------------------------------------------------------------
// bcd_rtc_epoch_clock_unit: 32-bit epoch seconds counter with BCD load
// Keeps seconds since 1970 and splits them into hour, minute and second.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one beat per command. LOAD converts the BCD date/time (years
//            2000..2099) into epoch seconds; TICK advances the tick divider
//            and bumps the count once per ticks_per_second ticks; READ (and
//            the spare code) leaves state alone.
//   out_*  : one beat per command: count after the command plus time of day.
//   cfg_*  : ticks_per_second write, always ready; write only while idle.
// Sequence: after accept, LOAD runs the hour, minute and second MAC steps
//   on the shared multiplier, then every command splits the count with
//   three reciprocal divisions (by 60, 60, 24), each a quotient step (S_DIV)
//   then a remainder step (S_REM), and S_DONE loads the output register.
//   in_ready returns with the presented beat, so a new command is taken
//   only after the previous one has finished.
//   in_ready is high only while idle; one command in flight at a time.
// Reset: count, tick phase cleared, ticks_per_second = 100, no beat pending.
// Stall: the finished beat holds in the output register; a new command may
//   be accepted meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module bcd_rtc_epoch_clock_unit
  import brec_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  brec_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output brec_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TPS_W-1:0] cfg_data
);

  brec_state_t      state_r, state_nxt;
  logic [31:0]      epoch_r, epoch_nxt;
  logic [TPS_W-1:0] phase_r, phase_nxt;
  logic [TPS_W-1:0] tps_r;
  logic [31:0]      work_r, work_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [1:0]       pass_r, pass_nxt;
  logic [7:0]       hour_r, hour_nxt;
  logic [7:0]       min_r, min_nxt;
  logic [7:0]       sec_r, sec_nxt;
  logic [5:0]       sof_r, sof_nxt;
  logic [5:0]       mof_r, mof_nxt;
  logic             out_valid_r, out_valid_nxt;
  brec_out_t        out_data_r, out_data_nxt;

  brec_alu_ctrl_t   alu_ctrl;
  logic [7:0]       alu_add;
  logic [31:0]      alu_y;
  logic [REM_W-1:0] alu_rem;

  logic             in_fire;
  logic [7:0]       yr, mon, day;
  logic [31:0]      load_days;
  logic [TPS_W:0]   phase_inc;

  brec_alu u_alu (
    .ctrl_i   (alu_ctrl),
    .a_i      (work_r),
    .rem_i    (rem_r),
    .addend_i (alu_add),
    .y_o      (alu_y),
    .rem_o    (alu_rem)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign yr  = bcd_byte_value(in_data.bcd_year);
  assign mon = bcd_byte_value(in_data.bcd_month);
  assign day = bcd_byte_value(in_data.bcd_day);

  // day count since 1970; a BCD day of zero gives the day before the first
  always_comb begin
    load_days = DAYS_TO_2000 + ({24'd0, yr} * DAYS_PER_YEAR)
              + 32'(({1'b0, yr} + 9'd3) >> 2) + {23'd0, month_start(mon)}
              + {24'd0, day} - 32'd1;
    if ((yr[1:0] == 2'd0) && (mon > 8'd2)) begin
      load_days = load_days + 32'd1;
    end
  end

  assign phase_inc = {1'b0, phase_r} + 17'd1;

  // ALU control: MAC chain hour/min/sec, then divides by 60, 60, 24
  always_comb begin
    alu_ctrl.op = ALU_DIV;
    if (state_r == S_MAC) begin
      alu_ctrl.op = ALU_MAC;
    end else if (state_r == S_REM) begin
      alu_ctrl.op = ALU_REM;
    end
    alu_add     = sec_r;
    case (pass_r)
      PASS_HOUR: alu_add = hour_r;
      PASS_MIN:  alu_add = min_r;
      default:   alu_add = sec_r;
    endcase
    if (state_r == S_MAC) begin
      alu_ctrl.k = (pass_r == PASS_HOUR) ? HOUR_PER_DAY : MIN_PER_HOUR;
    end else begin
      alu_ctrl.k = (pass_r == PASS_SEC) ? HOUR_PER_DAY : SEC_PER_MIN;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    epoch_nxt     = epoch_r;
    phase_nxt     = phase_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    pass_nxt      = pass_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    sec_nxt       = sec_r;
    sof_nxt       = sof_r;
    mof_nxt       = mof_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          rem_nxt  = '0;
          pass_nxt = PASS_HOUR;
          case (in_data.cmd)
            CMD_LOAD: begin
              work_nxt  = load_days;
              hour_nxt  = 8'(in_data.bcd_hour[6:4] * 8'd10) + 8'(in_data.bcd_hour[3:0]);
              min_nxt   = bcd_byte_value(in_data.bcd_minute);
              sec_nxt   = bcd_byte_value(in_data.bcd_second);
              state_nxt = S_MAC;
            end
            CMD_TICK: begin
              // a zero divisor behaves like one: next >= 0 always holds
              if (phase_inc >= {1'b0, tps_r}) begin
                phase_nxt = '0;
                epoch_nxt = epoch_r + 32'd1;
                work_nxt  = epoch_r + 32'd1;
              end else begin
                phase_nxt = phase_inc[TPS_W-1:0];
                work_nxt  = epoch_r;
              end
              state_nxt = S_DIV;
            end
            default: begin
              work_nxt  = epoch_r;
              state_nxt = S_DIV;
            end
          endcase
        end
      end
      S_MAC: begin
        work_nxt = alu_y;
        if (pass_r == PASS_SEC) begin
          epoch_nxt = alu_y;
          pass_nxt  = PASS_HOUR;
          state_nxt = S_DIV;
        end else begin
          pass_nxt = pass_r + 2'd1;
        end
      end
      S_DIV: begin
        work_nxt  = alu_y;
        rem_nxt   = alu_rem;
        state_nxt = S_REM;
      end
      S_REM: begin
        case (pass_r)
          PASS_HOUR: sof_nxt = alu_rem;
          PASS_MIN:  mof_nxt = alu_rem;
          default:   hour_nxt = {2'd0, alu_rem};
        endcase
        if (pass_r == PASS_SEC) begin
          state_nxt = S_DONE;
        end else begin
          pass_nxt  = pass_r + 2'd1;
          state_nxt = S_DIV;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.epoch_seconds    = epoch_r;
          out_data_nxt.hour_of_day      = hour_r[4:0];
          out_data_nxt.minute_of_hour   = mof_r;
          out_data_nxt.second_of_minute = sof_r;
          state_nxt                     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r     <= '0;
      phase_r     <= '0;
      tps_r       <= TPS_W'(100);
      out_valid_r <= 1'b0;
      pass_r      <= PASS_HOUR;
    end else begin
      epoch_r     <= epoch_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      pass_r      <= pass_nxt;
      if (cfg_valid && cfg_ready) begin
        tps_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    hour_r     <= hour_nxt;
    min_r      <= min_nxt;
    sec_r      <= sec_nxt;
    sof_r      <= sof_nxt;
    mof_r      <= mof_nxt;
    out_data_r <= out_data_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input accepted again while a command is in flight");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REM) |-> (alu_rem < alu_ctrl.k))
    else $error("remainder not below divisor");

  a_time_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.second_of_minute < 6'd60)
                 && (out_data_r.minute_of_hour < 6'd60)
                 && (out_data_r.hour_of_day < 5'd24))
    else $error("time of day field out of range");

  a_epoch_hold_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_REM) |=> $stable(epoch_r))
    else $error("epoch count changed during split");

endmodule
